/* rtl/bgtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtf_pkg
// Shared types and constants of the BMP grayscale / threshold filter.
// ----------------------------------------------------------------------------
package bgtf_pkg;

  // header byte positions
  localparam logic [31:0] OffsetPos   = 32'd10;
  localparam logic [31:0] WidthPos    = 32'd18;
  localparam logic [31:0] HeightPos   = 32'd22;
  localparam logic [31:0] ErrCheckPos = 32'd13;
  localparam logic [31:0] HeaderLen   = 32'd26;
  localparam logic [31:0] WordLast    = 32'd3;

  // configuration port
  localparam int unsigned AddrW = 2;
  localparam logic [AddrW-1:0] RegGrayMode = 2'd0;

  // divide by three: avg = (sum * 683) >> 11, exact for sums up to 765
  localparam int unsigned SumW        = 10;
  localparam int unsigned ProdW       = 21;
  localparam int unsigned Recip3      = 683;
  localparam int unsigned Recip3Shift = 11;
  localparam logic [7:0]  ThreshLevel = 8'd128;
  localparam logic [7:0]  ByteBlack   = 8'h00;
  localparam logic [7:0]  ByteWhite   = 8'hFF;

  // job queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    JOB_PASS  = 2'd0,  // one byte as given
    JOB_PAIR  = 2'd1,  // held blue then current byte (file ends mid pixel)
    JOB_PIXEL = 2'd2   // three bytes of the filtered pixel
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [SumW-1:0]   sum;
    logic              err;
  } job_t;

endpackage

/* rtl/bmp_grayscale_threshold_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_grayscale_threshold_filter
// 24-bit BMP byte stream filter: pixels become gray or black/white, all
// other bytes pass through unchanged.
// ----------------------------------------------------------------------------
// the first result byte of an accepted byte is written into the job queue and
//   then into the output stage register that drives the result ports (queue
//   and output stage empty)
// throughput: one input byte per cycle unless full; one result byte per cycle
//   while pop is high; a pixel's red byte yields three, buffered by a 4-job queue
// reset: all stream state cleared, gray_mode = 0 (threshold mode)
module bmp_grayscale_threshold_filter import bgtf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // byte input
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             end_of_file,
  // result output
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             header_error,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic gray_mode;
  logic job_wr;
  job_t job;
  logic fifo_rd;
  job_t fifo_data;
  logic fifo_full;
  logic fifo_empty;

  assign pready = 1'b1;
  assign prdata = (paddr == RegGrayMode) ? {31'b0, gray_mode} : '0;
  assign full   = fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == RegGrayMode) begin
      gray_mode <= pwdata[0];
    end
  end

  bgtf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .fifo_full   (fifo_full),
    .job_wr      (job_wr),
    .job         (job)
  );

  bgtf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_wr),
    .wr_data (job),
    .rd_en   (fifo_rd),
    .rd_data (fifo_data),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  bgtf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gray_mode    (gray_mode),
    .fifo_empty   (fifo_empty),
    .fifo_data    (fifo_data),
    .fifo_rd      (fifo_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .header_error (header_error)
  );

endmodule

/* rtl/bgtf_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtf_fifo
// Short flip-flop queue of jobs between the classifier and the output stage.
// ----------------------------------------------------------------------------
module bgtf_fifo import bgtf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  input  logic rd_en,
  output job_t rd_data,
  output logic full,
  output logic empty
);

  job_t                entries [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == FifoCntW'(FifoDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FifoCntW'(FifoDepth))
    else $error("job queue count beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("job written into full queue");

endmodule

/* rtl/bgtf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtf_front
// Accepts file bytes, tracks header and pixel position, and emits one job
// per byte that produces output.
// ----------------------------------------------------------------------------
module bgtf_front import bgtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       end_of_file,
  input  logic       fifo_full,
  output logic       job_wr,
  output job_t       job
);

  logic [31:0] byte_position, byte_position_next;
  logic [31:0] pixel_offset, pixel_offset_next;
  logic [31:0] image_width, image_width_next;
  logic [31:0] image_height, image_height_next;
  logic [7:0]  held_blue, held_blue_next;
  logic [7:0]  held_green, held_green_next;
  logic [1:0]  pixel_phase, pixel_phase_next;
  logic [31:0] column_count, column_count_next;
  logic [1:0]  pad_count, pad_count_next;
  logic [31:0] row_count, row_count_next;
  logic        region_done, region_done_next;

  logic        accept;
  logic [1:0]  lane;
  logic        err;
  logic        width_ok;
  logic        height_ok;
  logic        filtering;
  logic [1:0]  pad_need;
  logic        row_done;
  logic        job_valid;
  logic [31:0] column_inc;
  logic [31:0] row_inc;

  assign accept = push && !fifo_full;
  assign job_wr = accept && job_valid;

  always_comb begin
    // header words start at a position with low bits 2'b10
    lane               = byte_position[1:0] - 2'd2;
    pixel_offset_next  = pixel_offset;
    image_width_next   = image_width;
    image_height_next  = image_height;
    held_blue_next     = held_blue;
    held_green_next    = held_green;
    pixel_phase_next   = pixel_phase;
    column_count_next  = column_count;
    pad_count_next     = pad_count;
    row_count_next     = row_count;
    region_done_next   = region_done;
    row_done           = 1'b0;
    column_inc         = column_count + 32'd1;
    row_inc            = row_count + 32'd1;

    if (byte_position >= OffsetPos && byte_position <= OffsetPos + WordLast) begin
      pixel_offset_next[{lane, 3'b000} +: 8] = in_byte;
    end else if (byte_position >= WidthPos && byte_position <= WidthPos + WordLast) begin
      image_width_next[{lane, 3'b000} +: 8] = in_byte;
    end else if (byte_position >= HeightPos && byte_position <= HeightPos + WordLast) begin
      image_height_next[{lane, 3'b000} +: 8] = in_byte;
    end

    err       = (byte_position >= ErrCheckPos) && (pixel_offset_next < HeaderLen);
    width_ok  = (image_width_next != '0) && !image_width_next[31];
    height_ok = (image_height_next != '0) && !image_height_next[31];
    pad_need  = image_width_next[1:0];
    filtering = !err && !region_done && (byte_position >= HeaderLen)
                && (byte_position >= pixel_offset_next) && width_ok && height_ok;

    job.kind  = JOB_PASS;
    job.b0    = in_byte;
    job.b1    = in_byte;
    job.sum   = SumW'(held_blue) + SumW'(held_green) + SumW'(in_byte);
    job.err   = err;
    job_valid = 1'b1;

    if (filtering) begin
      if (column_count < image_width_next) begin
        case (pixel_phase)
          2'd0: begin
            held_blue_next   = in_byte;
            pixel_phase_next = 2'd1;
            job_valid        = end_of_file;
          end
          2'd1: begin
            held_green_next  = in_byte;
            pixel_phase_next = 2'd2;
            job_valid        = end_of_file;
            job.kind         = JOB_PAIR;
            job.b0           = held_blue;
          end
          default: begin
            job.kind          = JOB_PIXEL;
            pixel_phase_next  = 2'd0;
            column_count_next = column_inc;
            if (column_inc == image_width_next && pad_need == 2'd0) begin
              row_done = 1'b1;
            end
          end
        endcase
      end else begin
        // padding byte
        if ({1'b0, pad_count} + 3'd1 >= {1'b0, pad_need}) begin
          row_done = 1'b1;
        end else begin
          pad_count_next = pad_count + 2'd1;
        end
      end
    end

    if (row_done) begin
      column_count_next = '0;
      pad_count_next    = '0;
      row_count_next    = row_inc;
      if (row_inc == image_height_next) begin
        region_done_next = 1'b1;
      end
    end

    byte_position_next = (byte_position == '1) ? byte_position : byte_position + 32'd1;

    if (end_of_file) begin
      byte_position_next = '0;
      pixel_offset_next  = '0;
      image_width_next   = '0;
      image_height_next  = '0;
      held_blue_next     = '0;
      held_green_next    = '0;
      pixel_phase_next   = '0;
      column_count_next  = '0;
      pad_count_next     = '0;
      row_count_next     = '0;
      region_done_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pixel_offset  <= '0;
      image_width   <= '0;
      image_height  <= '0;
      held_blue     <= '0;
      held_green    <= '0;
      pixel_phase   <= '0;
      column_count  <= '0;
      pad_count     <= '0;
      row_count     <= '0;
      region_done   <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      pixel_offset  <= pixel_offset_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      held_blue     <= held_blue_next;
      held_green    <= held_green_next;
      pixel_phase   <= pixel_phase_next;
      column_count  <= column_count_next;
      pad_count     <= pad_count_next;
      row_count     <= row_count_next;
      region_done   <= region_done_next;
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    pixel_phase != 2'd3)
    else $error("pixel phase out of range");

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_file |=> byte_position == '0 && pixel_phase == 2'd0)
    else $error("state not cleared after end of file");

endmodule

/* rtl/bgtf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgtf_back
// Takes jobs from the queue, computes the pixel value and hands out one
// result byte per pop.
// ----------------------------------------------------------------------------
module bgtf_back import bgtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       gray_mode,
  input  logic       fifo_empty,
  input  job_t       fifo_data,
  output logic       fifo_rd,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       header_error
);

  logic             cur_valid;
  job_kind_t        cur_kind;
  logic [7:0]       cur_b0;
  logic [7:0]       cur_b1;
  logic             cur_err;
  logic [1:0]       idx;

  logic [ProdW-1:0] prod;
  logic [7:0]       avg;
  logic [7:0]       pix_val;
  logic [1:0]       last_idx;
  logic             take;
  logic             load;

  always_comb begin
    prod    = ProdW'(fifo_data.sum) * ProdW'(Recip3);
    avg     = prod[Recip3Shift +: 8];
    pix_val = gray_mode ? avg : ((avg < ThreshLevel) ? ByteBlack : ByteWhite);
  end

  always_comb begin
    unique case (cur_kind)
      JOB_PASS:  last_idx = 2'd0;
      JOB_PAIR:  last_idx = 2'd1;
      JOB_PIXEL: last_idx = 2'd2;
      default:   last_idx = 2'd0;
    endcase
  end

  assign empty        = !cur_valid;
  assign last_of_run  = (idx == last_idx);
  assign header_error = cur_err;
  assign out_byte     = (idx != 2'd0 && cur_kind == JOB_PAIR) ? cur_b1 : cur_b0;

  assign take    = pop && cur_valid;
  assign load    = !cur_valid || (take && last_of_run);
  assign fifo_rd = load && !fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_kind  <= JOB_PASS;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= !fifo_empty;
      cur_kind  <= fifo_data.kind;
      idx       <= '0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_rd) begin
      cur_b0  <= (fifo_data.kind == JOB_PIXEL) ? pix_val : fifo_data.b0;
      cur_b1  <= fifo_data.b1;
      cur_err <= fifo_data.err;
    end
  end

  a_pass_single: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur_kind == JOB_PASS |-> idx == 2'd0)
    else $error("pass job beyond its only byte");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur_kind == JOB_PAIR |-> idx != 2'd2 && idx != 2'd3)
    else $error("pair job beyond its second byte");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    fifo_rd |=> cur_valid && idx == 2'd0)
    else $error("loaded job not presented");

endmodule
